@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, disabled while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// plain invariant checked at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

@@ rtl/pqads_pkg.sv @@
// types and constants of the pq distance scanner
package pqads_pkg;

    localparam int SUB_W   = 3;
    localparam int CENT_W  = 8;
    localparam int DIM_W   = 4;
    localparam int RAW_W   = 16;
    localparam int CODE_W  = 64;
    localparam int TABLE_W = 36;
    localparam int DIST_W  = 39;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [TABLE_W-1:0] TABLE_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_SUBSPACES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTROIDS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_DIMS  = 2'd2;

    typedef enum logic [1:0] {
        OP_CB_WRITE = 2'd0,
        OP_QUERY    = 2'd1,
        OP_SCORE    = 2'd2
    } t_opcode;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [SUB_W-1:0]  sub_index;
        logic [CENT_W-1:0] centroid_index;
        logic [DIM_W-1:0]  dim_index;
        logic signed [RAW_W-1:0] element_value;
        logic [CODE_W-1:0] packed_code;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              code_out_of_range;
    } t_out_item;

    // control shared by all lanes
    typedef struct packed {
        logic              cb_we;
        logic              q_issue;
        logic              dim0;
        logic [SUB_W-1:0]  sub;
        logic [CENT_W-1:0] cent;
        logic [DIM_W-1:0]  dim;
    } t_lane_ctl;

endpackage

@@ rtl/pq_asymmetric_distance_scan.sv @@
// top level of the product-quantization asymmetric distance scanner
//
// One lane per subspace holds that subspace's codebook (centroids x dims) and
// its row of squared distances to the current query; lanes work side by side
// and an adder tree merges their entries into one distance. Per transfer:
// a codebook write is done from the transfer itself; a query element walks
// the centroids in use, one per cycle through a three-stage subtract /
// square / accumulate pipe, and then lets the pipe drain; a score reads
// every lane's table at once and its sum passes the adder tree registers
// into the result registers. Two result registers let one more item in
// while a result waits to be taken; input is refused while an item is in
// work or both result registers are full. Memories are not cleared at reset:
// read a codebook element or table entry only after writing it.
module pq_asymmetric_distance_scan import pqads_pkg::*; #(
    parameter int MAX_SUBSPACES = 8,
    parameter int MAX_CENTROIDS = 256,
    parameter int MAX_SUB_DIMS  = 16,
    parameter int VALUE_BITS    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LOW_W = (VALUE_BITS < RAW_W) ? VALUE_BITS : RAW_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_QWALK, ST_QDRAIN, ST_SCORE_RD, ST_SCORE_SUM
    } t_state;

    t_state r_state;
    logic [3:0]            r_m;      // clamped subspaces in use
    logic [8:0]            r_k;      // clamped centroids in use
    logic [4:0]            r_ds;     // clamped sub dims in use
    logic [SUB_W-1:0]      r_sub;
    logic [DIM_W-1:0]      r_dim;
    logic signed [VALUE_BITS-1:0] r_val;
    logic [8:0]            r_j;      // centroid walk counter
    logic [1:0]            r_drain;
    logic                  r_flag;
    logic                  r_out_valid;
    t_out_item             r_out;
    logic                  r_pend_valid;
    t_out_item             r_pend;   // second result behind the output one

    logic                  accept;
    logic                  take;
    logic                  res_done;
    t_out_item             result;
    logic signed [VALUE_BITS-1:0] in_val;
    logic                  flag;
    t_lane_ctl             ctl;
    logic [TABLE_W-1:0]    entry [MAX_SUBSPACES];
    logic                  merge_valid;
    logic [DIST_W-1:0]     merge_sum;

    assign o_in_ready = (r_state == ST_IDLE) && !r_pend_valid;
    assign accept     = i_in_valid && o_in_ready;
    assign take       = r_out_valid && i_out_ready;

    // low LOW_W bits of the raw element, zero-extended to VALUE_BITS and read as signed
    assign in_val = VALUE_BITS'(i_in_item.element_value[LOW_W-1:0]);

    // any used code byte at or above the centroid count flags the code
    always_comb begin
        flag = 1'b0;
        for (int i = 0; i < MAX_SUBSPACES; i++) begin
            if (i < int'(r_m) &&
                {1'b0, i_in_item.packed_code[8*i +: 8]} >= r_k) begin
                flag = 1'b1;
            end
        end
    end

    // lane control: codebook write straight from the transfer, query walk
    // from the held item
    always_comb begin
        ctl = '0;
        if (r_state == ST_IDLE) begin
            ctl.cb_we = accept && (i_in_item.opcode == OP_CB_WRITE) &&
                        (int'(i_in_item.sub_index) < MAX_SUBSPACES) &&
                        (int'(i_in_item.centroid_index) < MAX_CENTROIDS) &&
                        (int'(i_in_item.dim_index) < MAX_SUB_DIMS);
            ctl.sub  = i_in_item.sub_index;
            ctl.cent = i_in_item.centroid_index;
            ctl.dim  = i_in_item.dim_index;
        end else begin
            ctl.q_issue = (r_state == ST_QWALK);
            ctl.dim0    = (r_dim == '0);
            ctl.sub     = r_sub;
            ctl.cent    = r_j[CENT_W-1:0];
            ctl.dim     = r_dim;
        end
    end

    for (genvar l = 0; l < MAX_SUBSPACES; l++) begin : g_lane
        pqads_lane #(
            .LANE          (l),
            .MAX_CENTROIDS (MAX_CENTROIDS),
            .MAX_SUB_DIMS  (MAX_SUB_DIMS),
            .VALUE_BITS    (VALUE_BITS)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_value      ((r_state == ST_IDLE) ? in_val : r_val),
            .i_score_cent (i_in_item.packed_code[8*l +: 8]),
            .o_entry      (entry[l])
        );
    end

    pqads_merge #(.LANES(MAX_SUBSPACES)) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_state == ST_SCORE_RD),
        .i_used  (r_m),
        .i_entry (entry),
        .o_valid (merge_valid),
        .o_sum   (merge_sum)
    );

    // finished score: flagged codes report zero distance
    assign res_done                 = (r_state == ST_SCORE_SUM) && merge_valid;
    assign result.distance          = r_flag ? '0 : merge_sum;
    assign result.code_out_of_range = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_m          <= 4'(MAX_SUBSPACES);
            r_k          <= 9'(MAX_CENTROIDS);
            r_ds         <= 5'((MAX_SUB_DIMS > 16) ? 16 : MAX_SUB_DIMS);
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_j          <= '0;
            r_drain      <= '0;
        end else begin
            // registers are clamped into range as they are written
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SUBSPACES: begin
                        r_m <= (i_cfg_data[3:0] == '0) ? 4'd1 :
                               (int'(i_cfg_data[3:0]) > MAX_SUBSPACES) ?
                               4'(MAX_SUBSPACES) : i_cfg_data[3:0];
                    end
                    CFG_CENTROIDS: begin
                        r_k <= (i_cfg_data == '0) ? 9'd1 :
                               (int'(i_cfg_data) > MAX_CENTROIDS) ?
                               9'(MAX_CENTROIDS) : i_cfg_data;
                    end
                    CFG_SUB_DIMS: begin
                        r_ds <= (i_cfg_data[4:0] == '0) ? 5'd1 :
                                (int'(i_cfg_data[4:0]) > MAX_SUB_DIMS) ?
                                5'(MAX_SUB_DIMS) : i_cfg_data[4:0];
                    end
                    default: ;
                endcase
            end

            // a finished score goes to the output register, or behind it
            // while the output register still waits
            if (res_done) begin
                if (r_out_valid && !take) begin
                    r_pend_valid <= 1'b1;
                    r_pend       <= result;
                end else begin
                    r_out_valid <= 1'b1;
                    r_out       <= result;
                end
            end else if (take) begin
                r_out_valid  <= r_pend_valid;
                r_out        <= r_pend;
                r_pend_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_in_item.opcode)
                            OP_QUERY: begin
                                if ({1'b0, i_in_item.dim_index} < r_ds) begin
                                    r_state <= ST_QWALK;
                                    r_j     <= '0;
                                end
                            end
                            OP_SCORE: r_state <= ST_SCORE_RD;
                            default: ;
                        endcase
                    end
                end
                ST_QWALK: begin
                    r_j <= r_j + 9'd1;
                    if (r_j == r_k - 9'd1) begin
                        r_state <= ST_QDRAIN;
                        r_drain <= '0;
                    end
                end
                ST_QDRAIN: begin
                    // let the last centroid's write land
                    r_drain <= r_drain + 2'd1;
                    if (r_drain == 2'd2) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_SCORE_RD: r_state <= ST_SCORE_SUM;
                ST_SCORE_SUM: begin
                    if (merge_valid) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
        if (accept) begin
            r_sub  <= i_in_item.sub_index;
            r_dim  <= i_in_item.dim_index;
            r_val  <= in_val;
            r_flag <= flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ rtl/pqads_ram.sv @@
// generic single write, single registered read memory
module pqads_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pqads_lane.sv @@
// one subspace lane: codebook, distance table and squared-difference pipe
module pqads_lane import pqads_pkg::*; #(
    parameter int LANE          = 0,
    parameter int MAX_CENTROIDS = 256,
    parameter int MAX_SUB_DIMS  = 16,
    parameter int VALUE_BITS    = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_lane_ctl                    i_ctl,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic [CENT_W-1:0]            i_score_cent,
    output logic [TABLE_W-1:0]           o_entry
);

    localparam int CW       = $clog2(MAX_CENTROIDS);
    localparam int CB_DEPTH = MAX_CENTROIDS * MAX_SUB_DIMS;
    localparam int CBA_W    = $clog2(CB_DEPTH);
    localparam int DIFF_W   = VALUE_BITS + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int SUM_W    = ((SQ_W > TABLE_W) ? SQ_W : TABLE_W) + 1;

    logic                  sel;
    logic [CBA_W-1:0]      cb_addr;
    logic [VALUE_BITS-1:0] cb_rdata;
    logic [CW-1:0]         tbl_raddr;
    logic [TABLE_W-1:0]    tbl_rdata;
    logic [TABLE_W-1:0]    tbl_wdata;
    logic [SUM_W-1:0]      sum;
    logic signed [DIFF_W-1:0] diff;

    logic                     r_v1, r_v2, r_v3;
    logic                     r_dim0_1, r_dim0_2, r_dim0_3;
    logic [CW-1:0]            r_idx1, r_idx2, r_idx3;
    logic signed [DIFF_W-1:0] r_diff;
    logic [TABLE_W-1:0]       r_old2, r_old3;
    logic [SQ_W-1:0]          r_sq;

    assign sel     = (i_ctl.sub == SUB_W'(LANE));
    assign cb_addr = CBA_W'(CBA_W'(i_ctl.cent[CW-1:0]) * CBA_W'(MAX_SUB_DIMS))
                   + CBA_W'(i_ctl.dim);
    assign tbl_raddr = (i_ctl.q_issue && sel) ? i_ctl.cent[CW-1:0]
                                              : i_score_cent[CW-1:0];

    pqads_ram #(.WIDTH(VALUE_BITS), .DEPTH(CB_DEPTH)) u_codebook (
        .i_clk   (i_clk),
        .i_we    (i_ctl.cb_we && sel),
        .i_waddr (cb_addr),
        .i_wdata (i_value),
        .i_raddr (cb_addr),
        .o_rdata (cb_rdata)
    );

    pqads_ram #(.WIDTH(TABLE_W), .DEPTH(MAX_CENTROIDS)) u_table (
        .i_clk   (i_clk),
        .i_we    (r_v3),
        .i_waddr (r_idx3),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    assign diff = DIFF_W'(i_value) - DIFF_W'($signed(cb_rdata));
    assign sum  = r_dim0_3 ? SUM_W'(r_sq) : SUM_W'(r_old3) + SUM_W'(r_sq);
    assign tbl_wdata = (sum > SUM_W'(TABLE_MAX)) ? TABLE_MAX : sum[TABLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.q_issue && sel;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_idx1   <= i_ctl.cent[CW-1:0];
        r_dim0_1 <= i_ctl.dim0;
        r_diff   <= diff;
        r_old2   <= tbl_rdata;
        r_idx2   <= r_idx1;
        r_dim0_2 <= r_dim0_1;
        // square at full width so the product keeps all its bits
        r_sq     <= unsigned'(SQ_W'(r_diff) * SQ_W'(r_diff));
        r_old3   <= r_old2;
        r_idx3   <= r_idx2;
        r_dim0_3 <= r_dim0_2;
    end

    assign o_entry = tbl_rdata;

endmodule

@@ rtl/pqads_merge.sv @@
// two-level adder tree over the lane table entries
module pqads_merge import pqads_pkg::*; #(
    parameter int LANES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [3:0]         i_used,
    input  logic [TABLE_W-1:0] i_entry [LANES],
    output logic               o_valid,
    output logic [DIST_W-1:0]  o_sum
);

    localparam int PAIRS = (LANES + 1) / 2;

    logic [TABLE_W:0]   r_part [PAIRS];
    logic               r_v1, r_v2;
    logic [DIST_W-1:0]  r_sum;
    logic [DIST_W-1:0]  total;

    for (genvar p = 0; p < PAIRS; p++) begin : g_pair
        logic [TABLE_W:0] a, b;
        assign a = (2 * p < int'(i_used)) ? (TABLE_W + 1)'(i_entry[2 * p]) : '0;
        if (2 * p + 1 < LANES) begin : g_two
            assign b = (2 * p + 1 < int'(i_used)) ?
                       (TABLE_W + 1)'(i_entry[2 * p + 1]) : '0;
        end else begin : g_one
            assign b = '0;
        end
        always_ff @(posedge i_clk) begin
            r_part[p] <= a + b;
        end
    end

    always_comb begin
        total = '0;
        for (int p = 0; p < PAIRS; p++) begin
            total = total + DIST_W'(r_part[p]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_sum <= total;
    end

    assign o_valid = r_v2;
    assign o_sum   = r_sum;

endmodule

@@ rtl/pqads_checker.sv @@
// port-level checks of the distance scanner, bound to the top level
`include "assert_macros.svh"

module pqads_checker import pqads_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input t_in_item              i_in_item,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_item
);

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item), "result changed while stalled")
    `ASSERT_ALWAYS(a_flag_zero, i_clk, i_rst_n, !o_out_valid || !o_out_item.code_out_of_range || o_out_item.distance == '0, "flagged code with nonzero distance")
    `ASSERT_CLK(a_busy_after_score, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_item.opcode == OP_SCORE |=> !o_in_ready, "ready stayed high after a score transfer")

endmodule

bind pq_asymmetric_distance_scan pqads_checker u_pqads_checker (.*);
